[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants, operation codes and cell link types.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Number of entry slots in the store
  localparam int unsigned CAPACITY = 16;

  // Field widths
  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned ENTRY_COUNT_W = 5;
  localparam int unsigned CNT_W         = $clog2(CAPACITY + 1);

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NOP    = 2'd3
  } spq_func_e;

  // Decoded command broadcast to every cell
  typedef struct packed {
    logic                       ins;    // insert, store not full
    logic                       rem;    // remove, value found
    logic signed [VALUE_W-1:0]  value;
  } spq_cmd_t;

  // What one cell hands to its neighbours
  typedef struct packed {
    logic                       ge;     // slot empty or entry not below value
    logic signed [VALUE_W-1:0]  entry;
  } spq_link_t;

endpackage

[hw/rtl/spq_if.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if;
  import spq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;

  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic signed [VALUE_W-1:0]        head_value;
  logic                             head_valid;
  logic [ENTRY_COUNT_W-1:0]         entry_count;

  modport source (output valid, ok, head_value, head_valid, entry_count, input ready);
  modport sink   (input valid, ok, head_value, head_valid, entry_count, output ready);
endinterface

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted store; compares against the broadcast value and
// shifts towards either neighbour on insert or remove.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       occupied_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  spq_cmd_t                   cmd_i,
  input  spq_link_t                  left_i,
  input  spq_link_t                  right_i,
  output spq_link_t                  link_o,
  output logic                       hit_o,
  output logic signed [VALUE_W-1:0]  entry_d_o
);

  logic signed [VALUE_W-1:0] entry_q, entry_d;
  logic                      ge;
  logic                      first;

  // Locate the insertion / match point: first slot not below the value
  assign ge    = !occupied_i || !(entry_q < value_i);
  assign first = ge && !left_i.ge;
  assign hit_o = first && occupied_i && (entry_q == value_i);

  assign link_o.ge    = ge;
  assign link_o.entry = entry_q;

  // Shift right on insert, shift left on remove
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (left_i.ge) begin
        entry_d = left_i.entry;
      end else if (first) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.rem && ge) begin
      entry_d = right_i.entry;
    end
  end

  assign entry_d_o = entry_d;

  // Hold the entry between transactions
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
    end
  end

endmodule

[hw/rtl/sorted_priority_queue.sv]
// The response is registered and presented in the cycle after the request is accepted.
// Throughput: one operation per cycle while responses are drained; every cell compares and shifts at once.
// A request is taken while the response register is empty or being drained.
// Reset clears the entry count and the response valid flag; the entry slots
// keep no reset value and are read only below the count.
// ----------------------------------------------------------------------------
// Sorted priority queue
// Chain of sorted cells with a count register and a registered response.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  localparam int unsigned LAST = CAPACITY - 1;

  logic [CNT_W-1:0]          count_q, count_d;
  logic                      accept;
  logic                      full;
  logic                      found;
  spq_func_e                 func;
  spq_cmd_t                  cmd;

  spq_link_t                 links [CAPACITY];
  logic [CAPACITY-1:0]       hits;
  logic signed [VALUE_W-1:0] next_entry [CAPACITY];

  logic                      rsp_valid_q;
  logic                      ok_q, ok_d;
  logic signed [VALUE_W-1:0] head_q, head_d;
  logic                      head_valid_q;
  logic [ENTRY_COUNT_W-1:0]  entry_count_q;

  // Accept when the response register is free or draining
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign func  = spq_func_e'(req_i.func);
  assign full  = (count_q == CNT_W'(CAPACITY));
  assign found = |hits;

  // Decode the operation into cell commands
  always_comb begin
    cmd.ins   = (func == FUNC_INSERT) && !full;
    cmd.rem   = (func == FUNC_REMOVE) && found;
    cmd.value = req_i.value;
  end

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_link_t left_link, right_link;

    if (i == 0) begin : g_head
      assign left_link = '{ge: 1'b0, entry: '0};
    end else begin : g_mid_l
      assign left_link = links[i-1];
    end

    if (i == LAST) begin : g_tail
      assign right_link = links[i];
    end else begin : g_mid_r
      assign right_link = links[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .en_i       (accept),
      .occupied_i (count_q > CNT_W'(i)),
      .value_i    (req_i.value),
      .cmd_i      (cmd),
      .left_i     (left_link),
      .right_i    (right_link),
      .link_o     (links[i]),
      .hit_o      (hits[i]),
      .entry_d_o  (next_entry[i])
    );
  end

  // Next count and result
  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CNT_W'(1);
    end

    unique case (func)
      FUNC_INSERT: ok_d = !full;
      FUNC_REMOVE: ok_d = found;
      FUNC_LOOKUP: ok_d = found;
      default:     ok_d = 1'b0;
    endcase

    head_d = (count_d != '0) ? next_entry[0] : '0;
  end

  // Count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q          <= ok_d;
      head_q        <= head_d;
      head_valid_q  <= (count_d != '0);
      entry_count_q <= ENTRY_COUNT_W'(count_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.ok          = ok_q;
  assign rsp_o.head_value  = head_q;
  assign rsp_o.head_valid  = head_valid_q;
  assign rsp_o.entry_count = entry_count_q;

  // Count never exceeds the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A dropped insert leaves the count unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == FUNC_INSERT && full) |=> (count_q == $past(count_q)))
    else $error("insert into full store changed the count");

  // A lookup never alters the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == FUNC_LOOKUP) |=> (count_q == $past(count_q)))
    else $error("lookup changed the count");

  // Only one cell may claim the match point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hits))
    else $error("more than one cell reports a hit");

  // Head flag agrees with the count in a presented response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (head_valid_q == (count_q != '0)))
    else $error("head valid disagrees with count");

endmodule
